>>> src/priority_ordered_process_queue_assert.svh
// assertion macros shared by the priority queue rtl
`ifndef PRIORITY_ORDERED_PROCESS_QUEUE_ASSERT_SVH
`define PRIORITY_ORDERED_PROCESS_QUEUE_ASSERT_SVH

// property must hold on every clock edge outside reset
`define POPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent on one edge implies consequent on the next edge
`define POPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/popq_pkg.sv
// shared types and constants for the priority queue
package popq_pkg;

  localparam int ID_W         = 5;
  localparam int PRIO_PORT_W  = 8;
  localparam int COUNT_PORT_W = 6;

  localparam int MAX_ENTRIES_DEF   = 32;
  localparam int PRIORITY_BITS_DEF = 8;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_DUP  = 2'd2
  } status_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic ins;   // insert new entry at its ordered place
    logic del;   // take one entry out, close the gap
    logic pop;   // delete from the head, all cells shift
  } cell_ctl_t;

endpackage

>>> src/priority_ordered_process_queue.sv
// top level of the stable sorted priority queue of process ids
//
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+-------------------------------------
// command  | in        | start & !busy          | command, entry_id, entry_priority
// result   | out       | done (one cycle)       | status, taken_id, head_valid,
//          |           |                        | head_id, head_priority, entry_count
//
// every command completes at its accept edge: the cell row updates at that edge
// and the result is presented with done in the following cycle
// busy stays low, so a new command may be accepted each cycle
// rst is synchronous and empties the queue (valid bits and count cleared)
// the receiver cannot stall: done lasts exactly one cycle
module priority_ordered_process_queue #(
  parameter int MAX_ENTRIES   = popq_pkg::MAX_ENTRIES_DEF,
  parameter int PRIORITY_BITS = popq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         command,
  input  logic [popq_pkg::ID_W-1:0]          entry_id,
  input  logic [popq_pkg::PRIO_PORT_W-1:0]   entry_priority,
  output logic                               done,
  output logic [1:0]                         status,
  output logic [popq_pkg::ID_W-1:0]          taken_id,
  output logic                               head_valid,
  output logic [popq_pkg::ID_W-1:0]          head_id,
  output logic [popq_pkg::PRIO_PORT_W-1:0]   head_priority,
  output logic [popq_pkg::COUNT_PORT_W-1:0]  entry_count
);

  `include "priority_ordered_process_queue_assert.svh"

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // cell row state, slot 0 is the head
  logic [MAX_ENTRIES-1:0]         cell_valid;
  logic [popq_pkg::ID_W-1:0]      cell_id   [MAX_ENTRIES];
  logic [PRIORITY_BITS-1:0]       cell_prio [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]         cell_lt;
  logic [MAX_ENTRIES-1:0]         cell_seen;

  logic [CNT_W-1:0]               held_count;
  logic [CNT_W-1:0]               held_count_next;

  logic [PRIORITY_BITS-1:0]       new_prio;
  logic                           accept;
  logic                           dup;
  logic                           full;
  logic                           empty;
  popq_pkg::cell_ctl_t            ctl;
  popq_pkg::cmd_t                 cmd;

  popq_pkg::status_t              status_next;
  logic [popq_pkg::ID_W-1:0]      taken_next;

  // never busy, a command is accepted whenever start is high
  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign cmd      = popq_pkg::cmd_t'(command);
  // only the low priority bits take part in ordering
  assign new_prio = PRIORITY_BITS'(entry_priority);

  // the seen chain ripples along the row; its end flags the id as held
  assign dup   = cell_seen[MAX_ENTRIES-1];
  assign full  = cell_valid[MAX_ENTRIES-1];
  assign empty = !cell_valid[0];

  // decode command into the control word broadcast to the cells
  always_comb begin
    ctl         = '0;
    status_next = popq_pkg::ST_MISS;
    taken_next  = '0;
    case (cmd)
      popq_pkg::CMD_INSERT: begin
        if (dup) begin
          status_next = popq_pkg::ST_DUP;
        end else if (!full) begin
          ctl.ins     = accept;
          status_next = popq_pkg::ST_DONE;
        end
      end
      popq_pkg::CMD_POP: begin
        if (!empty) begin
          ctl.del     = accept;
          ctl.pop     = 1'b1;
          status_next = popq_pkg::ST_DONE;
          taken_next  = cell_id[0];
        end
      end
      popq_pkg::CMD_REMOVE: begin
        if (dup) begin
          ctl.del     = accept;
          status_next = popq_pkg::ST_DONE;
          taken_next  = entry_id;
        end
      end
      default: begin
        status_next = popq_pkg::ST_MISS;
      end
    endcase
  end

  // row of cells, each linked to its neighbors
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic                      up_valid;
    logic [popq_pkg::ID_W-1:0] up_id;
    logic [PRIORITY_BITS-1:0]  up_prio;
    logic                      up_lt;
    logic                      seen_in;
    logic                      dn_valid;
    logic [popq_pkg::ID_W-1:0] dn_id;
    logic [PRIORITY_BITS-1:0]  dn_prio;

    if (i == 0) begin : g_head
      // head takes the new entry directly and always becomes valid on insert
      assign up_valid = 1'b1;
      assign up_id    = entry_id;
      assign up_prio  = new_prio;
      assign up_lt    = 1'b0;
      assign seen_in  = 1'b0;
    end else begin : g_mid
      assign up_valid = cell_valid[i-1];
      assign up_id    = cell_id[i-1];
      assign up_prio  = cell_prio[i-1];
      assign up_lt    = cell_lt[i-1];
      assign seen_in  = cell_seen[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      // tail slot empties when the row shifts toward the head
      assign dn_valid = 1'b0;
      assign dn_id    = cell_id[i];
      assign dn_prio  = cell_prio[i];
    end else begin : g_body
      assign dn_valid = cell_valid[i+1];
      assign dn_id    = cell_id[i+1];
      assign dn_prio  = cell_prio[i+1];
    end

    popq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .new_id   (entry_id),
      .new_prio (new_prio),
      .up_valid (up_valid),
      .up_id    (up_id),
      .up_prio  (up_prio),
      .up_lt    (up_lt),
      .seen_in  (seen_in),
      .dn_valid (dn_valid),
      .dn_id    (dn_id),
      .dn_prio  (dn_prio),
      .valid    (cell_valid[i]),
      .id       (cell_id[i]),
      .prio     (cell_prio[i]),
      .lt       (cell_lt[i]),
      .seen_out (cell_seen[i])
    );
  end

  // entry count follows inserts and deletes
  always_comb begin
    held_count_next = held_count;
    if (ctl.ins) begin
      held_count_next = held_count + CNT_W'(1);
    end else if (ctl.del) begin
      held_count_next = held_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      done       <= 1'b0;
    end else begin
      held_count <= held_count_next;
      done       <= accept;
    end
  end

  // result payload captured at the accept edge
  always_ff @(posedge clk) begin
    if (accept) begin
      status   <= status_next;
      taken_id <= taken_next;
    end
  end

  // head fields read straight off slot 0, zero when empty
  assign head_valid    = cell_valid[0];
  assign head_id       = cell_valid[0] ? cell_id[0] : '0;
  assign head_priority = cell_valid[0] ? popq_pkg::PRIO_PORT_W'(cell_prio[0]) : '0;
  assign entry_count   = popq_pkg::COUNT_PORT_W'(held_count);

  `POPQ_ASSERT_ALWAYS(a_count_matches, $countones(cell_valid) == 32'(held_count), "bad count")
  `POPQ_ASSERT_ALWAYS(a_packed_row, ((cell_valid >> 1) & ~cell_valid) == '0, "row not packed")
  `POPQ_ASSERT_ALWAYS(a_head_order, !cell_valid[1] || cell_prio[0] >= cell_prio[1], "bad order")
  `POPQ_ASSERT_NEXT(a_done_follows, accept, done, "accepted item produced no result")

endmodule

>>> src/popq_cell.sv
// one slot of the sorted queue: holds an entry, shifts toward either neighbor
module popq_cell #(
  parameter int PRIORITY_BITS = popq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  popq_pkg::cell_ctl_t          ctl,
  input  logic [popq_pkg::ID_W-1:0]    new_id,
  input  logic [PRIORITY_BITS-1:0]     new_prio,
  // neighbor toward the head
  input  logic                         up_valid,
  input  logic [popq_pkg::ID_W-1:0]    up_id,
  input  logic [PRIORITY_BITS-1:0]     up_prio,
  input  logic                         up_lt,
  input  logic                         seen_in,
  // neighbor toward the tail
  input  logic                         dn_valid,
  input  logic [popq_pkg::ID_W-1:0]    dn_id,
  input  logic [PRIORITY_BITS-1:0]     dn_prio,
  // own state
  output logic                         valid,
  output logic [popq_pkg::ID_W-1:0]    id,
  output logic [PRIORITY_BITS-1:0]     prio,
  output logic                         lt,
  output logic                         seen_out
);

  logic match;
  logic shift_up;

  // empty slot or strictly lower priority: new entry goes here or above
  assign lt       = !valid || (prio < new_prio);
  assign match    = valid && (id == new_id);
  assign seen_out = seen_in || match;
  assign shift_up = ctl.del && (ctl.pop || seen_out);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.ins) begin
      valid <= valid || up_valid;
    end else if (shift_up) begin
      valid <= dn_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins && lt) begin
      if (up_lt) begin
        id   <= up_id;
        prio <= up_prio;
      end else begin
        id   <= new_id;
        prio <= new_prio;
      end
    end else if (shift_up) begin
      id   <= dn_id;
      prio <= dn_prio;
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the priority ordered process queue
module testbench;
  import popq_pkg::*;

  // block configuration, taken from the package defaults
  localparam int QUEUE_DEPTH = MAX_ENTRIES_DEF;
  localparam int PRIO_BITS   = PRIORITY_BITS_DEF;
  localparam int ID_SPACE    = 1 << ID_W;

  // only the low PRIO_BITS bits of a priority are stored
  localparam logic [PRIO_PORT_W-1:0] PRIO_MASK =
    PRIO_PORT_W'((64'd1 << PRIO_BITS) - 64'd1);

  // command code that the block does not define
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1800;  // random part stops once this many are planned
  localparam int CALM_TAIL    = 200;   // last items go out back to back
  localparam int DRAIN_CYCLES = 4;     // wait after the last result owed, to catch strays
  localparam int PRINT_LIMIT  = 100;   // keep the log short when things go badly wrong

  // one command item as it goes onto the bus
  typedef struct packed {
    logic [1:0]             cmd;
    logic [ID_W-1:0]        id;
    logic [PRIO_PORT_W-1:0] prio;
  } queue_cmd_t;

  // one result item as the block should present it
  typedef struct packed {
    status_t                 status;
    logic [ID_W-1:0]         taken_id;
    logic                    head_valid;
    logic [ID_W-1:0]         head_id;
    logic [PRIO_PORT_W-1:0]  head_priority;
    logic [COUNT_PORT_W-1:0] entry_count;
  } queue_result_t;

  // contents of the queue, slot 0 is the head, slots packed toward 0
  typedef struct {
    logic [ID_W-1:0]        ids   [QUEUE_DEPTH];
    logic [PRIO_PORT_W-1:0] prios [QUEUE_DEPTH];
    int                     count;
  } queue_state_t;

  // shapes of random traffic
  typedef enum int {GEN_FILL, GEN_DRAIN, GEN_MIX, GEN_NOISE} gen_mode_t;
  typedef enum int {PRIO_WIDE, PRIO_TIES, PRIO_NARROW} prio_style_t;

  // dut signals, inputs known from time zero
  logic                    clk            = 1'b0;
  logic                    rst            = 1'b1;
  logic                    start          = 1'b0;
  logic [1:0]              command        = CMD_INSERT;
  logic [ID_W-1:0]         entry_id       = '0;
  logic [PRIO_PORT_W-1:0]  entry_priority = '0;
  logic                    busy;
  logic                    done;
  logic [1:0]              status;
  logic [ID_W-1:0]         taken_id;
  logic                    head_valid;
  logic [ID_W-1:0]         head_id;
  logic [PRIO_PORT_W-1:0]  head_priority;
  logic [COUNT_PORT_W-1:0] entry_count;

  // planned items not yet accepted, and results still owed by the block
  queue_cmd_t    cmd_backlog[$];
  queue_result_t result_backlog[$];

  // queue contents as seen by the planner and as tracked at acceptance
  queue_state_t plan_state;
  queue_state_t model_state;

  int error_count  = 0;
  int results_seen = 0;
  int idle_left    = 0;  // remaining cycles of the current sender gap
  int calm_left    = 0;  // items still to go out without any gap

  always #2 clk = ~clk;

  priority_ordered_process_queue #(
    .MAX_ENTRIES   (QUEUE_DEPTH),
    .PRIORITY_BITS (PRIO_BITS)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .entry_id       (entry_id),
    .entry_priority (entry_priority),
    .done           (done),
    .status         (status),
    .taken_id       (taken_id),
    .head_valid     (head_valid),
    .head_id        (head_id),
    .head_priority  (head_priority),
    .entry_count    (entry_count)
  );

  // ------------------------------------------------------------------
  // queue behavior
  // ------------------------------------------------------------------

  function automatic int find_slot(input queue_state_t q, input logic [ID_W-1:0] id);
    for (int i = 0; i < q.count; i++) begin
      if (q.ids[i] == id) return i;
    end
    return -1;
  endfunction

  // applies one command to the queue and returns the result it causes
  function automatic queue_result_t queue_apply(inout queue_state_t q, input queue_cmd_t c);
    queue_result_t r;
    logic [PRIO_PORT_W-1:0] pr;
    int at;
    int k;
    r = '0;
    r.status = ST_MISS;
    pr = c.prio & PRIO_MASK;
    case (c.cmd)
      CMD_INSERT: begin
        // duplicate check comes first, so a full queue of all ids reports a duplicate
        if (find_slot(q, c.id) >= 0) begin
          r.status = ST_DUP;
        end else if (q.count < QUEUE_DEPTH) begin
          // land behind every entry of equal or higher priority
          k = 0;
          while (k < q.count && q.prios[k] >= pr) k++;
          for (int i = q.count; i > k; i--) begin
            q.ids[i]   = q.ids[i-1];
            q.prios[i] = q.prios[i-1];
          end
          q.ids[k]   = c.id;
          q.prios[k] = pr;
          q.count++;
          r.status = ST_DONE;
        end
      end
      CMD_POP, CMD_REMOVE: begin
        if (c.cmd == CMD_POP) at = (q.count > 0) ? 0 : -1;
        else                  at = find_slot(q, c.id);
        if (at >= 0) begin
          r.taken_id = q.ids[at];
          // close the gap toward the head
          for (int i = at; i + 1 < q.count; i++) begin
            q.ids[i]   = q.ids[i+1];
            q.prios[i] = q.prios[i+1];
          end
          q.count--;
          r.status = ST_DONE;
        end
      end
      default: ;  // unused code leaves the queue alone
    endcase
    if (q.count > 0) begin
      r.head_valid    = 1'b1;
      r.head_id       = q.ids[0];
      r.head_priority = q.prios[0];
    end
    r.entry_count = COUNT_PORT_W'(q.count);
    return r;
  endfunction

  // ------------------------------------------------------------------
  // stimulus planning
  // ------------------------------------------------------------------

  task automatic plan_item(input logic [1:0] cmd, input logic [ID_W-1:0] id,
                           input logic [PRIO_PORT_W-1:0] prio);
    queue_cmd_t c;
    c = {cmd, id, prio};
    cmd_backlog.push_back(c);
    void'(queue_apply(plan_state, c));
  endtask

  function automatic logic [ID_W-1:0] any_id();
    return ID_W'($urandom_range(0, ID_SPACE - 1));
  endfunction

  function automatic logic [PRIO_PORT_W-1:0] any_prio();
    return PRIO_PORT_W'($urandom_range(0, (1 << PRIO_PORT_W) - 1));
  endfunction

  // an id the queue holds at this point of the plan, or any id when empty
  function automatic logic [ID_W-1:0] held_id();
    if (plan_state.count == 0) return any_id();
    return plan_state.ids[$urandom_range(0, plan_state.count - 1)];
  endfunction

  // an id the queue does not hold, or a duplicate when every id is held
  function automatic logic [ID_W-1:0] free_id();
    logic [ID_W-1:0] base;
    logic [ID_W-1:0] cand;
    base = any_id();
    for (int n = 0; n < ID_SPACE; n++) begin
      cand = base + ID_W'(n);
      if (find_slot(plan_state, cand) < 0) return cand;
    end
    return base;
  endfunction

  function automatic logic [PRIO_PORT_W-1:0] pick_priority(input prio_style_t style);
    case (style)
      PRIO_TIES: begin
        // few distinct values so equal priorities pile up
        case ($urandom_range(0, 4))
          0:       return '0;
          1:       return PRIO_PORT_W'(1);
          2:       return PRIO_PORT_W'(128);
          3:       return PRIO_PORT_W'(254);
          default: return '1;
        endcase
      end
      PRIO_NARROW: return PRIO_PORT_W'($urandom_range(100, 103));
      default:     return any_prio();
    endcase
  endfunction

  // ------------------------------------------------------------------
  // checking
  // ------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_LIMIT) $display("mismatch: %s", msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h", results_seen, name, got, want));
  endtask

  // ------------------------------------------------------------------
  // driver: puts planned items on the bus, predicts each one accepted
  // ------------------------------------------------------------------

  always @(posedge clk) begin : drive_commands
    queue_result_t want;
    if (rst) begin
      start     <= 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        // the item on the bus is taken at this edge
        want = queue_apply(model_state, {command, entry_id, entry_priority});
        result_backlog.push_back(want);
        cmd_backlog.delete(0);
      end
      // while held off the item simply stays on the bus
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (cmd_backlog.size() == 0) begin
          start <= 1'b0;
        end else if (cmd_backlog.size() > CALM_TAIL && calm_left == 0 &&
                     $urandom_range(0, 7) == 0) begin
          // random sender gap, counting this cycle
          idle_left = $urandom_range(1, 13) - 1;
          start <= 1'b0;
        end else begin
          if (calm_left > 0) calm_left--;
          else if ($urandom_range(0, 24) == 0) calm_left = $urandom_range(20, 80);
          start          <= 1'b1;
          command        <= cmd_backlog[0].cmd;
          entry_id       <= cmd_backlog[0].id;
          entry_priority <= cmd_backlog[0].prio;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // monitor: every done pulse is matched against the oldest prediction
  // ------------------------------------------------------------------

  always @(posedge clk) begin : check_results
    queue_result_t want;
    if (!rst && done) begin
      results_seen++;
      if (result_backlog.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding", results_seen));
      end else begin
        want = result_backlog.pop_front();
        check_field("status",        status,        want.status);
        check_field("taken_id",      taken_id,      want.taken_id);
        check_field("head_valid",    head_valid,    want.head_valid);
        check_field("head_id",       head_id,       want.head_id);
        check_field("head_priority", head_priority, want.head_priority);
        check_field("entry_count",   entry_count,   want.entry_count);
      end
    end
  end

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------

  initial begin : run_test
    gen_mode_t   mode;
    prio_style_t style;
    int planned;
    int chunk;
    int roll;

    plan_state.count  = 0;
    model_state.count = 0;

    // directed part: empty queue corner cases
    plan_item(CMD_POP,    5'd0,  8'd0);     // pop on empty queue
    plan_item(CMD_REMOVE, 5'd0,  8'hff);    // remove from empty queue
    plan_item(CMD_UNUSED, 5'd31, 8'hff);    // unused code on empty queue
    // ordering, extremes of id and priority, ties keep arrival order
    plan_item(CMD_INSERT, 5'd31, 8'd0);
    plan_item(CMD_INSERT, 5'd0,  8'd255);   // new head
    plan_item(CMD_INSERT, 5'd16, 8'd255);   // equal to head, goes behind it
    plan_item(CMD_INSERT, 5'd31, 8'd200);   // id already held
    plan_item(CMD_INSERT, 5'd7,  8'd128);   // lands in the middle
    plan_item(CMD_INSERT, 5'd21, 8'd0);     // tie at the tail
    plan_item(CMD_UNUSED, 5'd7,  8'd0);     // unused code with entries held
    plan_item(CMD_REMOVE, 5'd16, 8'd0);     // second slot
    plan_item(CMD_REMOVE, 5'd21, 8'd0);     // tail
    plan_item(CMD_REMOVE, 5'd9,  8'd0);     // id not held
    plan_item(CMD_POP,    5'd31, 8'hff);
    plan_item(CMD_REMOVE, 5'd31, 8'd0);
    plan_item(CMD_POP,    5'd0,  8'd0);     // last entry out
    plan_item(CMD_POP,    5'd0,  8'd0);     // empty again
    plan_item(CMD_INSERT, 5'd10, 8'haa);
    plan_item(CMD_INSERT, 5'd5,  8'h55);
    plan_item(CMD_REMOVE, 5'd10, 8'd0);     // remove the head by name
    plan_item(CMD_REMOVE, 5'd5,  8'd0);
    plan_item(CMD_REMOVE, 5'd5,  8'd0);     // already gone

    // random part in chunks of one traffic shape each
    planned = 0;
    while (planned < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 9);
      if (roll < 4)      mode = GEN_FILL;
      else if (roll < 7) mode = GEN_DRAIN;
      else if (roll < 9) mode = GEN_MIX;
      else               mode = GEN_NOISE;
      style = prio_style_t'($urandom_range(0, 2));
      chunk = $urandom_range(16, 64);
      for (int n = 0; n < chunk; n++) begin
        roll = $urandom_range(0, 99);
        case (mode)
          GEN_FILL: begin
            // mostly new ids, so the queue runs up to full
            if (roll < 80)      plan_item(CMD_INSERT, free_id(), pick_priority(style));
            else if (roll < 88) plan_item(CMD_INSERT, held_id(), pick_priority(style));
            else if (roll < 94) plan_item(CMD_REMOVE, held_id(), any_prio());
            else                plan_item(CMD_POP, any_id(), any_prio());
          end
          GEN_DRAIN: begin
            if (roll < 45)      plan_item(CMD_POP, any_id(), any_prio());
            else if (roll < 80) plan_item(CMD_REMOVE, held_id(), any_prio());
            else if (roll < 90) plan_item(CMD_INSERT, free_id(), pick_priority(style));
            else                plan_item(CMD_REMOVE, any_id(), any_prio());
          end
          GEN_MIX: begin
            if (roll < 40)      plan_item(CMD_INSERT, free_id(), pick_priority(style));
            else if (roll < 70) plan_item(CMD_POP, any_id(), any_prio());
            else                plan_item(CMD_REMOVE, held_id(), any_prio());
          end
          default: begin
            // unused codes, misses and duplicates
            if (roll < 25)      plan_item(CMD_UNUSED, any_id(), any_prio());
            else if (roll < 50) plan_item(CMD_POP, any_id(), any_prio());
            else if (roll < 75) plan_item(CMD_REMOVE, any_id(), any_prio());
            else                plan_item(CMD_INSERT, any_id(), any_prio());
          end
        endcase
      end
      planned += chunk;
    end

    // reset once, then let the driver run the backlog
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || result_backlog.size() != 0) @(posedge clk);
    // catch any stray result after the last one owed
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && result_backlog.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin : watchdog
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/popq_pkg.sv
src/popq_cell.sv
src/priority_ordered_process_queue.sv
verif/testbench.sv
